[src/sobel_pkg.sv]
`timescale 1ns / 1ps
package sobel_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WLEN_W = COL_W + 1;
  localparam int HLEN_W = ROW_W + 1;

  localparam int PIX_W        = 8;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int THRESH_W     = 21;

  localparam int SUM_W  = PIX_W + 2;
  localparam int GRAD_W = PIX_W + 3;
  localparam int SQ_W   = 2 * (PIX_W + 2);
  localparam int MAG_W  = SQ_W + 1;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = HEIGHT_REG_W'(480);
  localparam logic [THRESH_W-1:0]     THRESH_RST = THRESH_W'(22500);

  localparam logic [PIX_W-1:0] EDGE_ON  = PIX_W'(255);
  localparam logic [PIX_W-1:0] EDGE_OFF = PIX_W'(0);

  typedef struct packed {
    logic [WLEN_W-1:0]   width;
    logic [HLEN_W-1:0]   height;
    logic [THRESH_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic                     valid;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    tag_t                     tag;
  } grad_t;

endpackage

[src/sobel_if.sv]
`timescale 1ns / 1ps
interface sobel_pix_if;
  import sobel_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface sobel_res_if;
  import sobel_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_value;
  logic [COL_W-1:0] out_column;
  logic [ROW_W-1:0] out_row;
  logic             frame_last;

  modport source (output valid, edge_value, out_column, out_row, frame_last, input ready);
  modport sink   (input valid, edge_value, out_column, out_row, frame_last, output ready);
endinterface

[src/sobel_cfg.sv]
`timescale 1ns / 1ps
module sobel_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sobel_pkg::APB_AW-1:0] paddr,
  input  logic [sobel_pkg::APB_DW-1:0] pwdata,
  output logic [sobel_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output sobel_pkg::cfg_t             cfg
);
  import sobel_pkg::*;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [THRESH_W-1:0]     threshold_squared;
  logic [1:0]              reg_sel;

  assign reg_sel = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= WIDTH_RST;
      image_height      <= HEIGHT_RST;
      threshold_squared <= THRESH_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_IMAGE_WIDTH:  image_width       <= pwdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height      <= pwdata[HEIGHT_REG_W-1:0];
        REG_THRESHOLD:    threshold_squared <= pwdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(image_height);
      REG_THRESHOLD:    prdata = APB_DW'(threshold_squared);
      default:          prdata = '0;
    endcase
  end

  // sizes are used clamped to the supported range
  always_comb begin
    if (image_width < WIDTH_REG_W'(3)) begin
      cfg.width = WLEN_W'(3);
    end else if (32'(image_width) > MAX_WIDTH) begin
      cfg.width = WLEN_W'(MAX_WIDTH);
    end else begin
      cfg.width = WLEN_W'(image_width);
    end
    if (image_height < HEIGHT_REG_W'(3)) begin
      cfg.height = HLEN_W'(3);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      cfg.height = HLEN_W'(MAX_HEIGHT);
    end else begin
      cfg.height = HLEN_W'(image_height);
    end
    cfg.threshold = threshold_squared;
  end

endmodule

[src/sobel_line.sv]
`timescale 1ns / 1ps
module sobel_line (
  input  logic             clk,
  input  logic             rst,
  input  sobel_pkg::cfg_t  cfg,
  sobel_pix_if.sink        pixels,
  input  logic             take,
  output sobel_pkg::grad_t grad
);
  import sobel_pkg::*;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] c_in;
  logic [ROW_W-1:0] r_in;
  logic             col_end;
  logic             row_end;
  logic             accept;

  logic             ld1;
  logic             ld2;
  logic             s1_go;

  logic             v1;
  logic [PIX_W-1:0] pix1;
  logic [COL_W-1:0] col1;
  logic [ROW_W-1:0] row1;
  logic             last1;

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] upper_rd;
  logic [PIX_W-1:0] middle_rd;

  logic             fwd1;
  logic [PIX_W-1:0] fwd_upper;
  logic [PIX_W-1:0] fwd_mid;

  logic [PIX_W-1:0] t0, m0, b0, t1, m1, b1;
  logic [PIX_W-1:0] t2, m2;

  logic [SUM_W-1:0]         left_sum, right_sum, top_sum, bot_sum;
  logic signed [GRAD_W-1:0] gx, gy;
  logic                     interior;

  logic                     v2;
  logic signed [GRAD_W-1:0] gx2, gy2;
  tag_t                     tag2;

  assign ld2 = !v2 || take;
  assign ld1 = !v1 || ld2;
  assign s1_go = v1 && ld2;

  assign pixels.ready = ld1;
  assign accept = pixels.valid && ld1;

  assign c_in = pixels.frame_start ? '0 : column_count;
  assign r_in = pixels.frame_start ? '0 : row_count;
  assign col_end = ({1'b0, c_in} + WLEN_W'(1)) >= cfg.width;
  assign row_end = ({1'b0, r_in} + HLEN_W'(1)) >= cfg.height;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : r_in + ROW_W'(1);
      end else begin
        column_count <= c_in + COL_W'(1);
        row_count    <= r_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1  <= pixels.pixel;
      col1  <= c_in;
      row1  <= r_in;
      last1 <= (({1'b0, c_in} + WLEN_W'(1)) == cfg.width) &&
               (({1'b0, r_in} + HLEN_W'(1)) == cfg.height);
    end
  end

  // row stores: read at accept, write back when the beat leaves stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      upper_rd  <= upper_mem[c_in];
      middle_rd <= middle_mem[c_in];
    end
    if (s1_go) begin
      upper_mem[col1]  <= m2;
      middle_mem[col1] <= pix1;
    end
  end

  // same column back to back: the read above misses the write in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd1 <= 1'b0;
    end else if (ld1) begin
      fwd1 <= accept && v1 && (c_in == col1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_upper <= m2;
      fwd_mid   <= pix1;
    end
  end

  assign t2 = fwd1 ? fwd_upper : upper_rd;
  assign m2 = fwd1 ? fwd_mid   : middle_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      t0 <= '0;
      m0 <= '0;
      b0 <= '0;
      t1 <= '0;
      m1 <= '0;
      b1 <= '0;
    end else if (s1_go) begin
      t0 <= t1;
      m0 <= m1;
      b0 <= b1;
      t1 <= t2;
      m1 <= m2;
      b1 <= pix1;
    end
  end

  assign left_sum  = {2'b00, t0} + {1'b0, m0, 1'b0} + {2'b00, b0};
  assign right_sum = {2'b00, t2} + {1'b0, m2, 1'b0} + {2'b00, pix1};
  assign top_sum   = {2'b00, t0} + {1'b0, t1, 1'b0} + {2'b00, t2};
  assign bot_sum   = {2'b00, b0} + {1'b0, b1, 1'b0} + {2'b00, pix1};
  assign gx = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
  assign gy = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
  assign interior = (col1 >= COL_W'(2)) && (row1 >= ROW_W'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1 && interior;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      gx2         <= gx;
      gy2         <= gy;
      tag2.column <= col1 - COL_W'(1);
      tag2.row    <= row1 - ROW_W'(1);
      tag2.last   <= last1;
    end
  end

  assign grad.valid = v2;
  assign grad.gx    = gx2;
  assign grad.gy    = gy2;
  assign grad.tag   = tag2;

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted beat did not reach stage 1");

  a_fwd_has_item: assert property (@(posedge clk) disable iff (rst)
    fwd1 |-> v1)
    else $error("forward flag set with stage 1 empty");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !ld2 |=> v1 && $stable(col1) && $stable(pix1))
    else $error("stalled stage 1 changed");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !take |=> v2 && $stable(gx2) && $stable(gy2))
    else $error("stalled gradient stage changed");

endmodule

[src/sobel_mag.sv]
`timescale 1ns / 1ps
module sobel_mag (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [sobel_pkg::THRESH_W-1:0] threshold,
  input  sobel_pkg::grad_t               grad,
  output logic                           take,
  sobel_res_if.source                    edges
);
  import sobel_pkg::*;

  logic                       ld_o;
  logic                       ld3;
  logic signed [2*GRAD_W-1:0] px, py;

  logic                       v3;
  logic [SQ_W-1:0]            sqx, sqy;
  tag_t                       tag3;

  logic [MAG_W-1:0]           mag;
  logic                       ov;
  logic                       is_edge;
  tag_t                       tag_o;

  assign ld_o = !ov || edges.ready;
  assign ld3  = !v3 || ld_o;
  assign take = ld3;

  assign px = grad.gx * grad.gx;
  assign py = grad.gy * grad.gy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ld3) begin
      v3 <= grad.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3 && grad.valid) begin
      sqx  <= px[SQ_W-1:0];
      sqy  <= py[SQ_W-1:0];
      tag3 <= grad.tag;
    end
  end

  assign mag = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ld_o) begin
      ov <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o && v3) begin
      is_edge <= mag > threshold;
      tag_o   <= tag3;
    end
  end

  assign edges.valid      = ov;
  assign edges.edge_value = is_edge ? EDGE_ON : EDGE_OFF;
  assign edges.out_column = tag_o.column;
  assign edges.out_row    = tag_o.row;
  assign edges.frame_last = tag_o.last;

  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    ov |-> (tag_o.column != '0) && (tag_o.row != '0))
    else $error("border pixel on output");

  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !ld_o |=> v3 && $stable(sqx) && $stable(sqy))
    else $error("stalled square stage changed");

  a_take_when_free: assert property (@(posedge clk) disable iff (rst)
    !v3 |-> take)
    else $error("empty square stage refused a beat");

endmodule

[src/sobel_edge_threshold.sv]
`timescale 1ns / 1ps
// Sobel edge detector: takes one 8-bit pixel per clock in raster order and
// returns one beat per interior pixel, 255 where Gx*Gx+Gy*Gy exceeds
// threshold_squared, else 0, tagged with its column, row and a last-of-frame
// mark. Border pixels produce no beat. It sustains one pixel per cycle unless
// output stalls, set by the two row stores, each with one read and one write
// port per cycle; a pixel whose column matches the one before it is served
// by forwarding. A result passes stage 1, gradient, square, output registers
// after its below-right pixel is accepted. Row stores are not cleared: after
// reset, send a frame from its start. Change sizes only between frames.
module sobel_edge_threshold (
  input  logic                         clk,
  input  logic                         rst,
  sobel_pix_if.sink                    pixels,
  sobel_res_if.source                  edges,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sobel_pkg::APB_AW-1:0] paddr,
  input  logic [sobel_pkg::APB_DW-1:0] pwdata,
  output logic [sobel_pkg::APB_DW-1:0] prdata,
  output logic                         pready
);
  import sobel_pkg::*;

  cfg_t  cfg;
  grad_t grad;
  logic  take;

  sobel_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sobel_line u_line (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pixels (pixels),
    .take   (take),
    .grad   (grad)
  );

  sobel_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .threshold (cfg.threshold),
    .grad      (grad),
    .take      (take),
    .edges     (edges)
  );

endmodule
